>>> hw/rtl/cfr_pkg.sv
// Shared types and constants for the checksummed frame receiver.
package cfr_pkg;

  localparam int unsigned MAX_PAYLOAD_DEF = 16;
  localparam logic [7:0]  START_BYTE      = 8'hFC;
  localparam logic [15:0] TIMEOUT_RESET   = 16'd200;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [1:0] {
    K_DATA    = 2'd0,
    K_END     = 2'd1,
    K_TIMEOUT = 2'd2,
    K_LENERR  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_CMD   = 3'd1,
    PH_HDR_A = 3'd2,
    PH_HDR_B = 3'd3,
    PH_LEN   = 3'd4,
    PH_DATA  = 3'd5,
    PH_CHECK = 3'd6
  } phase_e;

  typedef struct packed {
    logic       operation;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] command;
    logic [7:0] header_first;
    logic [7:0] header_second;
    logic [7:0] length;
    logic [3:0] byte_index;
    logic [7:0] byte_value;
    logic       checksum_ok;
  } result_t;

  typedef logic [15:0] cfg_word_t;

endpackage

>>> hw/rtl/cfr_stream_if.sv
// Valid/ready channel carrying one payload word per transaction.
interface cfr_stream_if #(
  parameter type data_t = logic
) ();
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/checksummed_frame_receiver.sv
// Top level of the checksummed frame receiver.
//
// in_i carries one item per transaction: a received serial byte or a one
// millisecond tick. Bytes are parsed as start byte 0xFC, command, two header
// bytes, length, payload and checksum. out_o returns at most one result per
// item: a payload byte with its index, frame end with checksum status, an
// idle timeout, or a length error. cfg_i writes the timeout in ticks; it is
// always ready and should only be written while the block is idle.
// An item enters the input register, then the parser updates its state and
// loads the output register, which drives the result onto out_o.
// Throughput is one item per cycle while out_o does not stall, set by the
// combinational parser step between the two registers.
// If out_o stalls, the output register holds the result and the input
// register still takes one more item; in_i then deasserts ready.
// Reset returns the parser to hunting for a start byte, clears frame state
// and sets the timeout to 200 ticks.
module checksummed_frame_receiver
  import cfr_pkg::*;
#(
  parameter int unsigned MaxPayload = MAX_PAYLOAD_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  cfr_stream_if.sink   in_i,
  cfr_stream_if.sink   cfg_i,
  cfr_stream_if.source out_o
);

  cfr_stream_if #(.data_t(in_item_t)) item_s ();
  cfr_stream_if #(.data_t(result_t))  res_s ();

  cfr_pipe_reg #(
    .data_t (in_item_t)
  ) u_in_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .s_i    (in_i),
    .m_o    (item_s)
  );

  cfr_frame_core #(
    .MaxPayload (MaxPayload)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (item_s),
    .cfg_i  (cfg_i),
    .res_o  (res_s)
  );

  cfr_pipe_reg #(
    .data_t (result_t)
  ) u_out_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .s_i    (res_s),
    .m_o    (out_o)
  );

endmodule

>>> hw/rtl/cfr_pipe_reg.sv
// Full-rate register slice on a valid/ready channel.
module cfr_pipe_reg #(
  parameter type data_t = logic
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  cfr_stream_if.sink   s_i,
  cfr_stream_if.source m_o
);

  logic  valid_q;
  data_t data_q;

  assign s_i.ready = !valid_q || m_o.ready;
  assign m_o.valid = valid_q;
  assign m_o.data  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s_i.valid && s_i.ready) begin
      valid_q <= 1'b1;
    end else if (m_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_i.valid && s_i.ready) begin
      data_q <= s_i.data;
    end
  end

endmodule

>>> hw/rtl/cfr_frame_core.sv
// Frame parser state, checksum, idle timeout and result formation.
module cfr_frame_core
  import cfr_pkg::*;
#(
  parameter int unsigned MaxPayload = MAX_PAYLOAD_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  cfr_stream_if.sink   item_i,
  cfr_stream_if.sink   cfg_i,
  cfr_stream_if.source res_o
);

  localparam int unsigned CntW = $clog2(MaxPayload + 1);

  phase_e          phase_q, phase_d;
  logic [7:0]      cmd_q, cmd_d;
  logic [7:0]      hdr_a_q, hdr_a_d;
  logic [7:0]      hdr_b_q, hdr_b_d;
  logic [7:0]      len_q, len_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [7:0]      sum_q, sum_d;
  logic [15:0]     idle_q, idle_d;
  logic [15:0]     timeout_q;

  logic            advance;
  logic            res_valid;
  result_t         res;
  logic [7:0]      b;
  logic [7:0]      sum_add;
  logic [CntW-1:0] cnt_inc;
  logic [15:0]     idle_inc;

  assign cfg_i.ready  = 1'b1;
  assign item_i.ready = res_o.ready;
  assign advance      = item_i.valid && item_i.ready;
  assign res_o.valid  = item_i.valid && res_valid;
  assign res_o.data   = res;

  assign b        = item_i.data.rx_byte;
  assign sum_add  = sum_q + b;
  assign cnt_inc  = cnt_q + CntW'(1);
  assign idle_inc = (idle_q == 16'hFFFF) ? idle_q : idle_q + 16'd1;

  always_comb begin
    phase_d   = phase_q;
    cmd_d     = cmd_q;
    hdr_a_d   = hdr_a_q;
    hdr_b_d   = hdr_b_q;
    len_d     = len_q;
    cnt_d     = cnt_q;
    sum_d     = sum_q;
    idle_d    = idle_q;
    res_valid = 1'b0;
    res       = '0;
    res.kind  = K_DATA;

    if (item_i.data.operation == OP_TICK) begin
      if (phase_q == PH_HUNT) begin
        idle_d = '0;
      end else begin
        idle_d = idle_inc;
        if (idle_inc >= timeout_q) begin
          res_valid = 1'b1;
          res.kind  = K_TIMEOUT;
          phase_d   = PH_HUNT;
          idle_d    = '0;
        end
      end
    end else begin
      idle_d = '0;
      unique case (phase_q)
        PH_HUNT: begin
          if (b == START_BYTE) begin
            cmd_d   = '0;
            hdr_a_d = '0;
            hdr_b_d = '0;
            len_d   = '0;
            cnt_d   = '0;
            sum_d   = '0;
            phase_d = PH_CMD;
          end
        end
        PH_CMD: begin
          cmd_d   = b;
          sum_d   = sum_add;
          phase_d = PH_HDR_A;
        end
        PH_HDR_A: begin
          hdr_a_d = b;
          sum_d   = sum_add;
          phase_d = PH_HDR_B;
        end
        PH_HDR_B: begin
          hdr_b_d = b;
          sum_d   = sum_add;
          phase_d = PH_LEN;
        end
        PH_LEN: begin
          len_d = b;
          sum_d = sum_add;
          cnt_d = '0;
          if (b > 8'(MaxPayload)) begin
            res_valid = 1'b1;
            res.kind  = K_LENERR;
            phase_d   = PH_HUNT;
          end else if (b == 8'd0) begin
            phase_d = PH_CHECK;
          end else begin
            phase_d = PH_DATA;
          end
        end
        PH_DATA: begin
          sum_d          = sum_add;
          res_valid      = 1'b1;
          res.kind       = K_DATA;
          res.byte_index = 4'(cnt_q);
          res.byte_value = b;
          cnt_d          = cnt_inc;
          if (8'(cnt_inc) >= len_q) begin
            phase_d = PH_CHECK;
          end
        end
        PH_CHECK: begin
          // checksum matches when it cancels the running sum
          res_valid       = 1'b1;
          res.kind        = K_END;
          res.checksum_ok = (sum_add == 8'd0);
          phase_d         = PH_HUNT;
        end
        default: begin
          phase_d = PH_HUNT;
        end
      endcase
    end

    res.command       = cmd_d;
    res.header_first  = hdr_a_d;
    res.header_second = hdr_b_d;
    res.length        = len_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      cmd_q   <= '0;
      hdr_a_q <= '0;
      hdr_b_q <= '0;
      len_q   <= '0;
      cnt_q   <= '0;
      sum_q   <= '0;
      idle_q  <= '0;
    end else if (advance) begin
      phase_q <= phase_d;
      cmd_q   <= cmd_d;
      hdr_a_q <= hdr_a_d;
      hdr_b_q <= hdr_b_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      sum_q   <= sum_d;
      idle_q  <= idle_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      timeout_q <= cfg_i.data;
    end
  end

endmodule
